>>> src/assert_macros.svh
// Assertion macros used by the top level of the subset enumerator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds at the same edge as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds at the edge after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/sce_pkg.sv
// Package of the subset enumerator: beat types, codes and default sizes.
package sce_pkg;

    // Default sizing of the enumerator.
    localparam int N_MAX_DEF = 32;
    localparam int K_MAX_DEF = 8;

    // Fixed widths of the beat fields.
    localparam int CNT_W      = 6;
    localparam int MASK_W     = 32;
    localparam int SIZE_OUT_W = 4;
    localparam int CFG_W      = 4;

    // Value of the size register after reset.
    localparam logic [CFG_W-1:0] MAX_FEAT_RESET = 4'd2;

    // Request codes.
    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    // One request beat.
    typedef struct packed {
        logic             req_type;
        logic [CNT_W-1:0] total_count;
    } in_beat_t;

    // One result beat.
    typedef struct packed {
        logic [MASK_W-1:0]     chosen_mask;
        logic [SIZE_OUT_W-1:0] subset_size;
        logic                  valid_res;
        logic                  final_subset;
    } out_beat_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic step;
        logic emit;
    } dp_cmd_t;

endpackage

>>> src/subset_combination_enumerator.sv
// Top level of the subset enumerator: controller, datapath and checks.
// Usage:
// A request beat on req either starts a new enumeration (req_type start,
// total_count gives the item count, saturated to N_MAX) or advances to the
// next subset. Each request beat gives exactly one result beat on res: a bit
// mask of the chosen items with its size, valid_res, and final_subset on the
// last subset of the whole enumeration. Sizes run from 1 up to the smaller of
// the size register capped at K_MAX and the item count minus one, subsets
// of one size in lexicographic order. The user writes the size register
// via cfg_we/cfg_data only while the block is idle (not enforced by the block);
// it is sampled at each start. Timing: an accept updates the index registers;
// the cycle after it, in the emit state, forms the result from them and no
// request is taken. While res_stall holds the result beat, req_stall stays high.
// Reset leaves no enumeration running, clears the result valid and sets the
// size register to 2; an advance before any start gives valid_res low.
`include "assert_macros.svh"

module subset_combination_enumerator #(
    parameter int N_MAX = sce_pkg::N_MAX_DEF,
    parameter int K_MAX = sce_pkg::K_MAX_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  sce_pkg::in_beat_t         req,
    output logic                      res_valid,
    input  logic                      res_stall,
    output sce_pkg::out_beat_t        res,
    input  logic                      cfg_we,
    input  logic [sce_pkg::CFG_W-1:0] cfg_data
);

    sce_pkg::dp_cmd_t cmd;

    // Sequencing and handshake.
    sce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .cmd       (cmd)
    );

    // Enumeration state and result register.
    sce_datapath #(
        .N_MAX (N_MAX),
        .K_MAX (K_MAX)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .res      (res)
    );

    // An accepted request blocks the next cycle and yields a result beat after the emit state.
    `ASSERT_NEXT(a_one_item_in_flight, req_valid && !req_stall, req_stall, "request accepted twice in a row")
    `ASSERT_IMPL(a_result_follows, req_valid && !req_stall, ##2 res_valid, "result beat missing after request")

    // An empty result carries no subset, and a given subset is never empty.
    `ASSERT_IMPL(a_empty_is_zero, res_valid && !res.valid_res, (res.chosen_mask == '0) && (res.subset_size == '0) && !res.final_subset, "empty result with nonzero fields")
    `ASSERT_IMPL(a_size_nonzero, res_valid && res.valid_res, res.subset_size != '0, "valid subset of size zero")

endmodule

>>> src/sce_ctrl.sv
// Controller of the subset enumerator: request handshake, result valid and sequencing.
module sce_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    output logic             res_valid,
    input  logic             res_stall,
    output sce_pkg::dp_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    // Take a request only when no result is formed and the result register is free.
    assign req_stall = (state_reg == ST_EMIT) || (out_valid_reg && res_stall);
    assign accept    = req_valid && !req_stall;
    assign res_valid = out_valid_reg;

    // The state update happens at the accept edge, the result is formed in the cycle after.
    assign cmd.step = accept;
    assign cmd.emit = (state_reg == ST_EMIT);

    // Next state and result valid.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (out_valid_reg && !res_stall)
                begin
                    out_valid_next = 1'b0;
                end
                if (accept)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> src/sce_datapath.sv
// Datapath of the subset enumerator: index registers, next-subset logic and result register.
module sce_datapath #(
    parameter int N_MAX = sce_pkg::N_MAX_DEF,
    parameter int K_MAX = sce_pkg::K_MAX_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sce_pkg::dp_cmd_t          cmd,
    input  sce_pkg::in_beat_t         req,
    input  logic                      cfg_we,
    input  logic [sce_pkg::CFG_W-1:0] cfg_data,
    output sce_pkg::out_beat_t        res
);

    localparam int IDX_W = $clog2(N_MAX);
    localparam int TW    = $clog2(N_MAX + 1);
    localparam int SZ_W  = $clog2(K_MAX + 1);
    localparam int PW    = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int CMP_W = $clog2(N_MAX + K_MAX + (1 << sce_pkg::CNT_W));

    // Enumeration state.
    logic [IDX_W-1:0]          idx_reg [K_MAX];
    logic [IDX_W-1:0]          idx_next [K_MAX];
    logic [SZ_W-1:0]           size_reg, size_next;
    logic [TW-1:0]             total_reg, total_next;
    logic [SZ_W-1:0]           limit_reg, limit_next;
    logic                      running_reg, running_next;
    logic                      pend_reg, pend_next;
    logic [sce_pkg::CFG_W-1:0] max_feat_reg;
    sce_pkg::out_beat_t        out_reg, out_next;

    // Helpers.
    logic [CMP_W-1:0]          top_val [K_MAX];
    logic [K_MAX-1:0]          can_inc;
    logic                      found;
    logic [PW-1:0]             sel;
    logic [IDX_W-1:0]          base;
    logic [TW-1:0]             n_sat;
    logic [CMP_W-1:0]          lim_feat;
    logic [CMP_W-1:0]          lim;
    logic [sce_pkg::MASK_W-1:0] mask;
    logic                      last_of_size;
    logic                      last;

    // Highest value each position may hold for the current size.
    always_comb
    begin
        for (int p = 0; p < K_MAX; p++)
        begin
            top_val[p] = CMP_W'(total_reg) + CMP_W'(p) - CMP_W'(size_reg);
        end
    end

    // Priority select of the highest position that can still be raised.
    always_comb
    begin
        found = 1'b0;
        sel   = '0;
        for (int p = 0; p < K_MAX; p++)
        begin
            can_inc[p] = (CMP_W'(p) < CMP_W'(size_reg)) &&
                         (CMP_W'(idx_reg[p]) < top_val[p]);
            if (can_inc[p])
            begin
                found = 1'b1;
                sel   = PW'(p);
            end
        end
        base = idx_reg[sel] + IDX_W'(1);
    end

    // Saturated count and size limit of a new enumeration.
    always_comb
    begin
        if (CMP_W'(req.total_count) > CMP_W'(N_MAX))
        begin
            n_sat = TW'(N_MAX);
        end
        else
        begin
            n_sat = TW'(req.total_count);
        end
        if (CMP_W'(max_feat_reg) > CMP_W'(K_MAX))
        begin
            lim_feat = CMP_W'(K_MAX);
        end
        else
        begin
            lim_feat = CMP_W'(max_feat_reg);
        end
        priority if (n_sat == '0)
        begin
            lim = '0;
        end
        else if (lim_feat > CMP_W'(n_sat) - CMP_W'(1))
        begin
            lim = CMP_W'(n_sat) - CMP_W'(1);
        end
        else
        begin
            lim = lim_feat;
        end
    end

    // Mask and end test of the current subset; indices of 32 and above shift out.
    always_comb
    begin
        mask         = '0;
        last_of_size = 1'b1;
        for (int p = 0; p < K_MAX; p++)
        begin
            if (CMP_W'(p) < CMP_W'(size_reg))
            begin
                mask = mask | (sce_pkg::MASK_W'(1) << idx_reg[p]);
                if (CMP_W'(idx_reg[p]) != top_val[p])
                begin
                    last_of_size = 1'b0;
                end
            end
        end
        last = pend_reg && (size_reg >= limit_reg) && last_of_size;
    end

    // Next state for a request beat or for forming a result.
    always_comb
    begin
        idx_next     = idx_reg;
        size_next    = size_reg;
        total_next   = total_reg;
        limit_next   = limit_reg;
        running_next = running_reg;
        pend_next    = pend_reg;
        out_next     = out_reg;
        if (cmd.step)
        begin
            if (req.req_type == sce_pkg::REQ_START)
            begin
                total_next = n_sat;
                limit_next = SZ_W'(lim);
                for (int i = 0; i < K_MAX; i++)
                begin
                    idx_next[i] = '0;
                end
                if (lim == '0)
                begin
                    running_next = 1'b0;
                    size_next    = '0;
                    pend_next    = 1'b0;
                end
                else
                begin
                    running_next = 1'b1;
                    size_next    = SZ_W'(1);
                    pend_next    = 1'b1;
                end
            end
            else if (!running_reg)
            begin
                pend_next = 1'b0;
            end
            else if (found)
            begin
                // Raise the selected position and pack the following ones behind it.
                for (int m = 0; m < K_MAX; m++)
                begin
                    if (CMP_W'(m) == CMP_W'(sel))
                    begin
                        idx_next[m] = base;
                    end
                    else if ((CMP_W'(m) > CMP_W'(sel)) && (CMP_W'(m) < CMP_W'(size_reg)))
                    begin
                        idx_next[m] = base + IDX_W'(m) - IDX_W'(sel);
                    end
                end
                pend_next = 1'b1;
            end
            else if (size_reg >= limit_reg)
            begin
                running_next = 1'b0;
                pend_next    = 1'b0;
            end
            else
            begin
                // First subset of the next size.
                size_next = size_reg + SZ_W'(1);
                for (int i = 0; i < K_MAX; i++)
                begin
                    if (CMP_W'(i) <= CMP_W'(size_reg))
                    begin
                        idx_next[i] = IDX_W'(i);
                    end
                    else
                    begin
                        idx_next[i] = '0;
                    end
                end
                pend_next = 1'b1;
            end
        end
        else if (cmd.emit)
        begin
            if (pend_reg)
            begin
                out_next.chosen_mask  = mask;
                out_next.subset_size  = sce_pkg::SIZE_OUT_W'(size_reg);
                out_next.valid_res    = 1'b1;
                out_next.final_subset = last;
            end
            else
            begin
                out_next = '0;
            end
            running_next = running_reg && !last;
        end
    end

    // Enumeration state and configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < K_MAX; i++)
            begin
                idx_reg[i] <= '0;
            end
            size_reg     <= '0;
            total_reg    <= '0;
            limit_reg    <= '0;
            running_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            max_feat_reg <= sce_pkg::MAX_FEAT_RESET;
        end
        else
        begin
            idx_reg     <= idx_next;
            size_reg    <= size_next;
            total_reg   <= total_next;
            limit_reg   <= limit_next;
            running_reg <= running_next;
            pend_reg    <= pend_next;
            if (cfg_we)
            begin
                max_feat_reg <= cfg_data;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign res = out_reg;

endmodule
